### src/sm3_pkg.sv
// Package for the SM3 hash engine: controller state type, command/status structs,
// initial value, round constants and helper functions. No dependencies.
package sm3_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ZERO,
      ST_COMP,
      ST_FOLD,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic put_byte;
      logic put_pad;
      logic put_zero;
      logic put_len;
      logic round_init;
      logic round_step;
      logic fold;
      logic add_block;
      logic clear_all;
   } cmd_type;

   typedef struct packed {
      logic [5:0] byte_count;
      logic [5:0] round;
   } status_type;

   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam logic [31:0] T_LOW = 32'h79CC4519;
   localparam logic [31:0] T_HIGH = 32'h7A879D8A;

   localparam logic [255:0] SM3_IV = {
      32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
      32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
   };

   function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
      logic [63:0] d;
      d = {x, x} << n;
      return d[63:32];
   endfunction

   function automatic logic [31:0] perm0(input logic [31:0] x);
      return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
   endfunction

   function automatic logic [31:0] perm1(input logic [31:0] x);
      return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
   endfunction

endpackage

### src/sm3_hash_engine.sv
// Top level of the SM3 hash engine: joins controller and datapath.
// Depends on sm3_pkg, sm3_control and sm3_datapath.
//
//   channel  direction  fields
//   req_     in         data_byte, has_byte, last
//   rsp_     out        word_index, digest_word, last_word
//
// A byte request is taken while idle; a request that fills a block then runs
// ST_COMP to load the rounds, ST_FOLD for the rounds with the fold on the last,
// and ST_OUT to return. A last request adds the padding walk, one or two
// compressions, and eight digest words.
// Reset is synchronous and active high and restores the initial value.
// Requests stall during padding, compression and digest output; a stalled digest
// word holds.
module sm3_hash_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_word_index,
   output logic [31:0] rsp_digest_word,
   output logic        rsp_last_word
);
   import sm3_pkg::*;

   cmd_type cmd;
   status_type status;
   logic [2:0] sel;

   sm3_control u_control (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_has_byte(req_has_byte), .req_last(req_last), .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall), .out_sel(sel), .cmd(cmd), .status(status)
   );

   sm3_datapath u_datapath (
      .clock(clock), .reset(reset), .cmd(cmd), .byte_in(req_data_byte),
      .out_sel(sel), .status(status), .word_out(rsp_digest_word)
   );

   assign rsp_word_index = sel;
   assign rsp_last_word = (sel == 3'd7);
endmodule

### src/sm3_datapath.sv
// Datapath of the SM3 hash engine: block buffer, message expansion window,
// round registers, chaining value and length counter. Uses sm3_pkg.
module sm3_datapath (
   input  logic                clock,
   input  logic                reset,
   input  sm3_pkg::cmd_type    cmd,
   input  logic [7:0]          byte_in,
   input  logic [2:0]          out_sel,
   output sm3_pkg::status_type status,
   output logic [31:0]         word_out
);
   import sm3_pkg::*;

   logic [31:0] buf_ff [16];
   logic [31:0] win_ff [16];
   logic [31:0] win_in [16];
   logic [255:0] chain_ff, chain_in;
   logic [255:0] work_ff, work_in;
   logic [5:0] count_ff, count_in;
   logic [5:0] round_ff, round_in;
   logic [63:0] bits_ff, bits_in;
   logic [63:0] total;
   logic [3:0] widx;
   logic [4:0] bsh;
   logic [7:0] bval;
   logic [31:0] a, b, c, d, e, f, g, h;
   logic [31:0] tc, a12, ss1, ss2, ff_v, gg_v, tt1, tt2, wnew;

   assign total = bits_ff + {55'd0, count_ff, 3'd0};
   assign widx = count_ff[5:2];
   assign bsh = {~count_ff[1:0], 3'd0};
   assign bval = cmd.put_pad ? PAD_BYTE : (cmd.put_byte ? byte_in : 8'd0);
   assign {a, b, c, d, e, f, g, h} = work_ff;

   always_comb begin
      tc = rotl(round_ff < 6'd16 ? T_LOW : T_HIGH, round_ff[4:0]);
      a12 = rotl(a, 5'd12);
      ss1 = rotl(a12 + e + tc, 5'd7);
      ss2 = ss1 ^ a12;
      if (round_ff < 6'd16) begin
         ff_v = a ^ b ^ c;
         gg_v = e ^ f ^ g;
      end else begin
         ff_v = (a & b) | (a & c) | (b & c);
         gg_v = (e & f) | (~e & g);
      end
      tt1 = ff_v + d + ss2 + (win_ff[0] ^ win_ff[4]);
      tt2 = gg_v + h + ss1 + win_ff[0];
      wnew = perm1(win_ff[0] ^ win_ff[7] ^ rotl(win_ff[13], 5'd15))
         ^ rotl(win_ff[3], 5'd7) ^ win_ff[10];
      for (int i = 0; i < 15; i++) begin
         win_in[i] = win_ff[i + 1];
      end
      win_in[15] = wnew;
      work_in = {tt1, a, rotl(b, 5'd9), c, perm0(tt2), e, rotl(f, 5'd19), g};
      chain_in = chain_ff ^ work_in;
      count_in = count_ff + 6'd1;
      round_in = round_ff + 6'd1;
      bits_in = bits_ff + 64'd512;
   end

   always_ff @(posedge clock) begin
      if (cmd.put_byte || cmd.put_pad || cmd.put_zero) begin
         buf_ff[widx] <= (buf_ff[widx] & ~(32'hFF << bsh)) | ({24'd0, bval} << bsh);
      end
      if (cmd.put_len) begin
         buf_ff[14] <= bits_ff[63:32];
         buf_ff[15] <= bits_ff[31:0];
      end
      if (cmd.round_init) begin
         win_ff <= buf_ff;
         work_ff <= chain_ff;
      end else if (cmd.round_step) begin
         win_ff <= win_in;
         work_ff <= work_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_all) begin
         chain_ff <= SM3_IV;
         count_ff <= '0;
         bits_ff <= '0;
         round_ff <= '0;
      end else begin
         if (cmd.fold) begin
            chain_ff <= chain_in;
         end
         if (cmd.put_byte || cmd.put_pad || cmd.put_zero) begin
            count_ff <= count_in;
         end
         if (cmd.put_len) begin
            count_ff <= '0;
         end
         if (cmd.add_block) begin
            bits_ff <= bits_in;
         end
         if (cmd.put_pad) begin
            bits_ff <= total;
         end
         if (cmd.round_init) begin
            round_ff <= '0;
         end else if (cmd.round_step) begin
            round_ff <= round_in;
         end
      end
   end

   assign status.byte_count = count_ff;
   assign status.round = round_ff;
   assign word_out = chain_ff[255 - 32 * out_sel -: 32];
endmodule

### src/sm3_control.sv
// Controller of the SM3 hash engine: request acceptance, padding sequence,
// round counting and digest output. Uses sm3_pkg.
module sm3_control (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_has_byte,
   input  logic                req_last,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [2:0]          out_sel,
   output sm3_pkg::cmd_type    cmd,
   input  sm3_pkg::status_type status
);
   import sm3_pkg::*;

   state_type state_ff, state_in;
   logic final_ff, final_in;
   logic pad_ff, pad_in;
   logic [2:0] sel_ff, sel_in;
   logic acc;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         final_ff <= 1'b0;
         pad_ff <= 1'b0;
         sel_ff <= '0;
      end else begin
         state_ff <= state_in;
         final_ff <= final_in;
         pad_ff <= pad_in;
         sel_ff <= sel_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      final_in = final_ff;
      pad_in = pad_ff;
      sel_in = sel_ff;
      cmd = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      acc = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            acc = req_valid;
            if (acc) begin
               final_in = req_last;
               pad_in = 1'b0;
               if (req_has_byte) begin
                  cmd.put_byte = 1'b1;
                  if (status.byte_count == 6'd63) begin
                     state_in = ST_COMP;
                     cmd.round_init = 1'b0;
                  end
               end
               if (req_last && !(req_has_byte && status.byte_count == 6'd63)) begin
                  state_in = ST_ZERO;
               end
            end
         end
         ST_ZERO: begin
            if (!pad_ff) begin
               cmd.put_pad = 1'b1;
               pad_in = 1'b1;
               if (status.byte_count == 6'd63) begin
                  state_in = ST_COMP;
               end
            end else if (status.byte_count == 6'd56) begin
               cmd.put_len = 1'b1;
               final_in = 1'b0;
               state_in = ST_COMP;
            end else begin
               cmd.put_zero = 1'b1;
               if (status.byte_count == 6'd63) begin
                  state_in = ST_COMP;
               end
            end
         end
         ST_COMP: begin
            cmd.round_init = 1'b1;
            state_in = ST_FOLD;
         end
         ST_FOLD: begin
            cmd.round_step = 1'b1;
            if (status.round == 6'd63) begin
               cmd.fold = 1'b1;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!pad_ff && !final_ff) begin
               cmd.add_block = 1'b1;
               state_in = ST_IDLE;
            end else if (!pad_ff) begin
               cmd.add_block = 1'b1;
               state_in = ST_ZERO;
            end else if (final_ff) begin
               state_in = ST_ZERO;
            end else begin
               state_in = ST_IDLE;
               state_in = ST_OUT;
               rsp_valid = 1'b1;
               if (!rsp_stall) begin
                  sel_in = sel_ff + 3'd1;
                  if (sel_ff == 3'd7) begin
                     cmd.clear_all = 1'b1;
                     pad_in = 1'b0;
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign out_sel = sel_ff;
endmodule

### src/sm3_checker.sv
// Port checker for the SM3 hash engine with its bind statement.
// Depends on the sm3_hash_engine ports only.
module sm3_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_word_index,
   input logic [31:0] rsp_digest_word,
   input logic        rsp_last_word
);
   a_stall_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("request taken during digest");
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_word == (rsp_word_index == 3'd7)))
      else $error("last word flag wrong");
   a_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_word |=>
      rsp_valid && rsp_word_index == $past(rsp_word_index) + 3'd1)
      else $error("digest words out of order");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_digest_word))
      else $error("stalled digest word changed");
endmodule

bind sm3_hash_engine sm3_checker u_checker (.*);

### verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for sm3_hash_engine: byte requests in, digest words out.
// Depends on sm3_pkg (initial value, round constants) and the engine RTL.
module tb;
   import sm3_pkg::*;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       last;
   } byte_req_t;

   typedef struct packed {
      logic [2:0]  word_index;
      logic [31:0] digest_word;
      logic        last_word;
   } digest_rsp_t;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_data_byte;
   logic        req_has_byte;
   logic        req_last;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_word_index;
   logic [31:0] rsp_digest_word;
   logic        rsp_last_word;

   byte_req_t   pending_reqs[$];
   digest_rsp_t expected_words[$];
   int          mismatch_count;
   int          send_gap;
   int          recv_gap;
   int          hold_off_cycles;
   bit          stimulus_done;

   logic [31:0] msg_words[16];
   logic [5:0]  msg_bytes;
   logic [63:0] msg_bits;
   logic [31:0] chain[8];

   sm3_hash_engine u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_data_byte(req_data_byte), .req_has_byte(req_has_byte), .req_last(req_last),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_word_index(rsp_word_index), .rsp_digest_word(rsp_digest_word),
      .rsp_last_word(rsp_last_word)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic logic [31:0] rol32(logic [31:0] x, int n);
      n = n % 32;
      if (n == 0) begin
         return x;
      end
      return (x << n) | (x >> (32 - n));
   endfunction

   function automatic logic [31:0] p0_of(logic [31:0] x);
      return x ^ rol32(x, 9) ^ rol32(x, 17);
   endfunction

   function automatic logic [31:0] p1_of(logic [31:0] x);
      return x ^ rol32(x, 15) ^ rol32(x, 23);
   endfunction

   function automatic void restart_hash();
      for (int i = 0; i < 16; i++) begin
         msg_words[i] = '0;
      end
      for (int i = 0; i < 8; i++) begin
         chain[i] = SM3_IV[255 - 32 * i -: 32];
      end
      msg_bytes = '0;
      msg_bits = '0;
   endfunction

   function automatic void compress_msg_block();
      logic [31:0] w[68];
      logic [31:0] a, b, c, d, e, f, g, h, ss1, ss2, tt1, tt2, ff, gg, a12, t;
      for (int j = 0; j < 16; j++) begin
         w[j] = msg_words[j];
      end
      for (int j = 16; j < 68; j++) begin
         w[j] = p1_of(w[j-16] ^ w[j-9] ^ rol32(w[j-3], 15)) ^ rol32(w[j-13], 7) ^ w[j-6];
      end
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
      e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
      for (int j = 0; j < 64; j++) begin
         t = rol32(j < 16 ? T_LOW : T_HIGH, j % 32);
         a12 = rol32(a, 12);
         ss1 = rol32(a12 + e + t, 7);
         ss2 = ss1 ^ a12;
         if (j < 16) begin
            ff = a ^ b ^ c;
            gg = e ^ f ^ g;
         end else begin
            ff = (a & b) | (a & c) | (b & c);
            gg = (e & f) | (~e & g);
         end
         tt1 = ff + d + ss2 + (w[j] ^ w[j+4]);
         tt2 = gg + h + ss1 + w[j];
         d = c; c = rol32(b, 9); b = a; a = tt1;
         h = g; g = rol32(f, 19); f = e; e = p0_of(tt2);
      end
      chain[0] ^= a; chain[1] ^= b; chain[2] ^= c; chain[3] ^= d;
      chain[4] ^= e; chain[5] ^= f; chain[6] ^= g; chain[7] ^= h;
   endfunction

   function automatic void store_msg_byte(logic [7:0] v);
      int sh;
      sh = (3 - msg_bytes[1:0]) * 8;
      msg_words[msg_bytes[5:2]] = (msg_words[msg_bytes[5:2]] & ~(32'hFF << sh))
                                  | (32'(v) << sh);
      msg_bytes = msg_bytes + 6'd1;
   endfunction

   function automatic void predict_digest(byte_req_t r);
      logic [63:0] total;
      digest_rsp_t x;
      if (r.has_byte) begin
         store_msg_byte(r.data_byte);
         if (msg_bytes == 0) begin
            compress_msg_block();
            msg_bits = msg_bits + 64'd512;
         end
      end
      if (!r.last) begin
         return;
      end
      total = msg_bits + {55'd0, msg_bytes, 3'd0};
      store_msg_byte(PAD_BYTE);
      if (msg_bytes > 56 || msg_bytes == 0) begin
         while (msg_bytes != 0) begin
            store_msg_byte(8'h00);
         end
         compress_msg_block();
      end
      while (msg_bytes < 56) begin
         store_msg_byte(8'h00);
      end
      msg_words[14] = total[63:32];
      msg_words[15] = total[31:0];
      compress_msg_block();
      for (int i = 0; i < 8; i++) begin
         x.word_index = 3'(i);
         x.digest_word = chain[i];
         x.last_word = (i == 7);
         expected_words.push_back(x);
      end
      restart_hash();
   endfunction

   function automatic void queue_message(int len, bit with_last_byte, int byte_mode);
      byte_req_t r;
      for (int i = 0; i < len; i++) begin
         case (byte_mode)
            1: r.data_byte = 8'h00;
            2: r.data_byte = 8'hFF;
            default: r.data_byte = 8'($urandom_range(0, 255));
         endcase
         r.has_byte = 1'b1;
         r.last = (i == len - 1) && with_last_byte;
         pending_reqs.push_back(r);
         if (($urandom_range(0, 9) == 0) && !r.last) begin
            r.has_byte = 1'b0;
            r.data_byte = 8'($urandom_range(0, 255));
            r.last = 1'b0;
            pending_reqs.push_back(r);
         end
      end
      if (!with_last_byte || len == 0) begin
         r.data_byte = 8'($urandom_range(0, 255));
         r.has_byte = 1'b0;
         r.last = 1'b1;
         pending_reqs.push_back(r);
      end
   endfunction

   // Driver: requests are offered in order with random gaps between them.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
      end else if (!(req_valid && req_stall)) begin
         if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (pending_reqs.size() > 0) begin
            byte_req_t r;
            r = pending_reqs.pop_front();
            predict_digest(r);
            req_valid <= 1'b1;
            req_data_byte <= r.data_byte;
            req_has_byte <= r.has_byte;
            req_last <= r.last;
            if ($urandom_range(0, 3) == 0) begin
               send_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                       : $urandom_range(1, 3);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver stall pattern, including a long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_gap <= 0;
      end else if (hold_off_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_off_cycles <= hold_off_cycles - 1;
      end else if (recv_gap > 0) begin
         rsp_stall <= 1'b1;
         recv_gap <= recv_gap - 1;
      end else if ($urandom_range(0, 4) == 0) begin
         rsp_stall <= 1'b1;
         recv_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                 : $urandom_range(0, 2);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Monitor: every accepted digest word is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         digest_rsp_t got;
         got = '{rsp_word_index, rsp_digest_word, rsp_last_word};
         if (expected_words.size() == 0) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10) begin
               $display("unexpected digest word: index %0d word %08h last %0b",
                        got.word_index, got.digest_word, got.last_word);
            end
         end else begin
            digest_rsp_t want;
            want = expected_words.pop_front();
            if (got !== want) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < 10) begin
                  $display("digest word differs: expected %0d/%08h/%0b got %0d/%08h/%0b",
                           want.word_index, want.digest_word, want.last_word,
                           got.word_index, got.digest_word, got.last_word);
               end
            end
         end
      end
   end

   initial begin
      int len;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data_byte = '0;
      req_has_byte = 1'b0;
      req_last = 1'b0;
      rsp_stall = 1'b0;
      mismatch_count = 0;
      hold_off_cycles = 0;
      stimulus_done = 1'b0;
      restart_hash();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part: empty message, a bare empty request, all-zero and all-one bytes,
      // and the lengths around the padding boundary.
      queue_message(0, 1'b0, 0);
      begin
         byte_req_t r;
         r = '{8'hA5, 1'b0, 1'b0};
         pending_reqs.push_back(r);
      end
      queue_message(3, 1'b1, 2);
      queue_message(4, 1'b0, 1);
      queue_message(7, 1'b1, 0);
      wait (pending_reqs.size() == 0);
      queue_message(56, 1'b1, 2);
      queue_message(64, 1'b1, 0);

      // Long receiver hold-off while requests keep coming.
      hold_off_cycles = 400;
      for (int m = 0; m < 2; m++) begin
         queue_message($urandom_range(1, 6), $urandom_range(0, 1), 0);
      end

      // Sender pauses until every digest word has come back.
      wait (pending_reqs.size() == 0 && expected_words.size() == 0);
      repeat (200) @(posedge clock);

      for (int m = 0; m < 3; m++) begin
         len = $urandom_range(0, 4);
         queue_message(len, $urandom_range(0, 1), $urandom_range(0, 9) == 0 ? 2 : 0);
      end

      wait (pending_reqs.size() == 0);
      @(posedge clock);
      wait (!(req_valid && req_stall));
      @(posedge clock);
      wait (expected_words.size() == 0);
      repeat (300) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("sm3_hash_engine: match");
      end else begin
         $display("sm3_hash_engine: mismatch");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("sm3_hash_engine: mismatch");
      $finish;
   end
endmodule

### files.f
src/sm3_pkg.sv
src/sm3_datapath.sv
src/sm3_control.sv
src/sm3_hash_engine.sv
src/sm3_checker.sv
verif/tb.sv
